[src/b64c_pkg.sv]
// ----------------------------------------------------------------------------
// b64c_pkg
// Types and symbol helpers shared by the streaming base64 codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SymW    = 6;
  localparam int unsigned StoreW  = 6;   // pending bits never exceed one symbol
  localparam int unsigned CountW  = 3;   // pending bit count, 0..6
  localparam int unsigned MaxRes  = 4;   // results per item at most
  localparam int unsigned ResCntW = 3;   // 0..MaxRes

  localparam logic [ByteW-1:0] PadChar = 8'h3D;  // '='

  typedef enum logic {
    DirEncode = 1'b0,
    DirDecode = 1'b1
  } dir_e;

  typedef struct packed {
    logic [StoreW-1:0] store;
    logic [CountW-1:0] count;
    logic              halted;
  } b64c_state_t;

  typedef struct packed {
    logic [MaxRes-1:0][ByteW-1:0] chars;
    logic [ResCntW-1:0]           cnt;
  } b64c_result_t;

  // 6-bit value to alphabet character
  function automatic logic [ByteW-1:0] enc_sym(input logic [SymW-1:0] v);
    logic [ByteW-1:0] w;
    w = {2'b00, v};
    if (v < 6'd26)      return 8'h41 + w;          // 'A'
    else if (v < 6'd52) return 8'h61 + w - 8'd26;  // 'a'
    else if (v < 6'd62) return 8'h30 + w - 8'd52;  // '0'
    else if (v == 6'd62) return 8'h2B;             // '+'
    else                 return 8'h2F;             // '/'
  endfunction

  // alphabet character to {valid, value}; '=' and everything else is invalid
  function automatic logic [SymW:0] dec_sym(input logic [ByteW-1:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return {1'b1, SymW'(c - 8'h41)};
    if (c >= 8'h61 && c <= 8'h7A) return {1'b1, SymW'(c - 8'h61 + 8'd26)};
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, SymW'(c - 8'h30 + 8'd52)};
    if (c == 8'h2B) return {1'b1, 6'd62};
    if (c == 8'h2F) return {1'b1, 6'd63};
    return {1'b0, 6'd0};
  endfunction

endpackage

[src/b64c_step.sv]
// ----------------------------------------------------------------------------
// b64c_step
// Combinational next-state and result generation for one item.
// ----------------------------------------------------------------------------
module b64c_step import b64c_pkg::*; (
  input  dir_e             dir_i,
  input  b64c_state_t      state_i,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             eom_i,
  output b64c_state_t      state_o,
  output b64c_result_t     result_o
);

  always_comb begin
    logic [9:0]        acc10;
    logic [11:0]       acc12;
    logic [7:0]        acc8;
    logic [3:0]        rem;
    logic [CountW-1:0] rem_n;
    logic [SymW:0]     dv;

    state_o  = state_i;
    result_o = '0;
    acc10    = '0;
    acc12    = '0;
    acc8     = '0;
    rem      = '0;
    rem_n    = '0;
    dv       = dec_sym(in_byte_i);

    if (dir_i == DirEncode) begin
      unique case (state_i.count)
        3'd2: begin
          acc10 = {state_i.store[1:0], in_byte_i};
          result_o.chars[0] = enc_sym(acc10[9:4]);
          result_o.cnt      = 3'd1;
          rem   = in_byte_i[3:0];
          rem_n = 3'd4;
        end
        3'd4: begin
          acc12 = {state_i.store[3:0], in_byte_i};
          result_o.chars[0] = enc_sym(acc12[11:6]);
          result_o.chars[1] = enc_sym(acc12[5:0]);
          result_o.cnt      = 3'd2;
        end
        default: begin
          result_o.chars[0] = enc_sym(in_byte_i[7:2]);
          result_o.cnt      = 3'd1;
          rem   = {2'b00, in_byte_i[1:0]};
          rem_n = 3'd2;
        end
      endcase
      state_o.store = {2'b00, rem};
      state_o.count = rem_n;
      if (eom_i) begin
        // flush leftover bits left-aligned, then pad to a full quad
        if (rem_n == 3'd2) begin
          result_o.chars[1] = enc_sym({rem[1:0], 4'b0000});
          result_o.chars[2] = PadChar;
          result_o.chars[3] = PadChar;
          result_o.cnt      = 3'd4;
        end else if (rem_n == 3'd4) begin
          result_o.chars[1] = enc_sym({rem, 2'b00});
          result_o.chars[2] = PadChar;
          result_o.cnt      = 3'd3;
        end
      end
    end else if (!state_i.halted) begin
      if (!dv[SymW]) begin
        state_o.halted = 1'b1;
      end else begin
        unique case (state_i.count)
          3'd6: begin
            acc12 = {state_i.store, dv[SymW-1:0]};
            result_o.chars[0] = acc12[11:4];
            result_o.cnt      = 3'd1;
            state_o.store = {2'b00, acc12[3:0]};
            state_o.count = 3'd4;
          end
          3'd4: begin
            acc10 = {state_i.store[3:0], dv[SymW-1:0]};
            result_o.chars[0] = acc10[9:2];
            result_o.cnt      = 3'd1;
            state_o.store = {4'b0000, acc10[1:0]};
            state_o.count = 3'd2;
          end
          3'd2: begin
            acc8 = {state_i.store[1:0], dv[SymW-1:0]};
            result_o.chars[0] = acc8;
            result_o.cnt      = 3'd1;
            state_o.store = '0;
            state_o.count = 3'd0;
          end
          default: begin
            state_o.store = dv[SymW-1:0];
            state_o.count = 3'd6;
          end
        endcase
      end
    end

    if (eom_i) state_o = '0;
  end

endmodule

[src/base64_stream_codec.sv]
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming base64 encoder/decoder, standard alphabet, direction register.
// ----------------------------------------------------------------------------
//  channel | signals                                  | role
//  --------+------------------------------------------+-----------------------
//  in      | in_valid_i/in_ready_o, in_byte_i,        | byte or character,
//          | end_of_message_i                         | message end flag
//  out     | out_valid_o/out_ready_i, out_byte_o,     | character or byte,
//          | run_last_o                               | last of this item
//  cfg     | cfg_we_i, cfg_wdata_i                    | direction, clears state
//
// An item waits in the input register until the result buffer is free, then
// its results (0..4) are computed in one pass into the result buffer and
// leave one per cycle while out_ready_i is high; the next item may load as
// the last result leaves. A full buffer with out stalled holds one more item
// in the input register. Reset clears direction, state, input flag, count.
// ----------------------------------------------------------------------------
module base64_stream_codec import b64c_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             end_of_message_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             run_last_o
);

  dir_e                         dir_q;
  b64c_state_t                  state_q, state_d;
  b64c_result_t                 result_d;

  logic                         in_full_q;
  logic [ByteW-1:0]             in_byte_q;
  logic                         in_eom_q;

  logic [MaxRes-1:0][ByteW-1:0] chars_q;
  logic [ResCntW-1:0]           rem_q;
  logic [1:0]                   idx_q;

  logic out_xfer, last_xfer, buf_free, load, in_xfer;

  assign out_valid_o = (rem_q != '0);
  assign out_byte_o  = chars_q[idx_q];
  assign run_last_o  = (rem_q == ResCntW'(1));

  assign out_xfer  = out_valid_o && out_ready_i;
  assign last_xfer = out_xfer && run_last_o;
  assign buf_free  = !out_valid_o || last_xfer;
  assign load      = in_full_q && buf_free;
  assign in_ready_o = !in_full_q || load;
  assign in_xfer   = in_valid_i && in_ready_o;

  b64c_step u_step (
    .dir_i     (dir_q),
    .state_i   (state_q),
    .in_byte_i (in_byte_q),
    .eom_i     (in_eom_q),
    .state_o   (state_d),
    .result_o  (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= DirEncode;
      state_q <= '0;
    end else if (cfg_we_i) begin
      dir_q   <= dir_e'(cfg_wdata_i);
      state_q <= '0;
    end else if (load) begin
      state_q <= state_d;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_xfer) begin
      in_full_q <= 1'b1;
    end else if (load) begin
      in_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= in_byte_i;
      in_eom_q  <= end_of_message_i;
    end
  end

  // result buffer, drained one transfer per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else if (load) begin
      rem_q <= result_d.cnt;
      idx_q <= '0;
    end else if (out_xfer) begin
      rem_q <= rem_q - ResCntW'(1);
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) chars_q <= result_d.chars;
  end

endmodule
